// ===== sv/scl2x_pkg.sv =====
`timescale 1ns / 1ps

package scl2x_pkg;

  localparam int PIX_W     = 8;
  localparam int PAL_DEPTH = 256;
  localparam int COLOR_W   = 32;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 8;
  localparam int POS_W     = 10;
  localparam int ROW_LIM_W = 11;
  localparam int BLK_SLOTS = 3;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_W-1:0]     FRAME_WIDTH_RST  = 11'd320;
  localparam logic [CFG_W-1:0]     FRAME_HEIGHT_RST = 11'd200;
  localparam logic [ROW_LIM_W-1:0] MAX_ROWS         = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 8'd1;

  localparam logic FUNC_PALETTE = 1'b0;
  localparam logic FUNC_PIXEL   = 1'b1;

  typedef struct packed {
    logic               func;
    logic [PIX_W-1:0]   pixel_index;
    logic [COLOR_W-1:0] palette_color;
  } scl2x_in_t;

  typedef struct packed {
    logic [POS_W-1:0]   src_col;
    logic [POS_W-1:0]   src_row;
    logic [COLOR_W-1:0] top_left;
    logic [COLOR_W-1:0] top_right;
    logic [COLOR_W-1:0] bottom_left;
    logic [COLOR_W-1:0] bottom_right;
    logic               last_of_run;
  } scl2x_out_t;

  // palette indices of one block: above, left, center, right, below
  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] dn;
    logic [PIX_W-1:0] ctr;
    logic [PIX_W-1:0] rt;
    logic [PIX_W-1:0] lo;
  } scl2x_blk_t;

  typedef struct packed {
    logic                            is_pixel;
    logic [BLK_SLOTS-1:0]            blk_vld;
    scl2x_blk_t [BLK_SLOTS-1:0]      blk;
    logic [PIX_W-1:0]                pal_addr;
    logic [COLOR_W-1:0]              pal_color;
  } scl2x_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } scl2x_qstat_t;

endpackage

// ===== sv/scale2x_pixel_upscaler_top.sv =====
`timescale 1ns / 1ps
// channel  ports                          request
// -------  -----------------------------  -----------------------------------------
// input    in_valid in_stall in_data      palette write or one source pixel
// result   out_valid out_stall out_data   one 2x2 block of palette colors
// config   cfg_we cfg_index cfg_wdata     frame_width (0), frame_height (1)
//
// One input request per cycle unless stalled; a pixel yields up to three blocks,
// issued one per cycle unless stalled, from three palette copies; a 4-entry queue
// absorbs the burst. out_valid follows the front stage, queue and result register.
// Synchronous active-low reset clears control only, not palette or line stores.
// in_stall rises while the queue is full and the front stage holds a request;
// out_stall, with out_valid high, holds the result register and stops block issue.

module scale2x_pixel_upscaler_top import scl2x_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int COLOR_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  scl2x_in_t            in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output scl2x_out_t           out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  scl2x_qstat_t q_stat;
  scl2x_job_t   q_job, q_head;
  logic         q_push, q_pop;

  scl2x_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  scl2x_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .stat     (q_stat),
    .head     (q_head)
  );

  scl2x_back #(
    .COLOR_BITS (COLOR_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== sv/scl2x_front.sv =====
`timescale 1ns / 1ps

module scl2x_front import scl2x_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  scl2x_in_t            in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  scl2x_qstat_t         q_stat,
  output logic                 q_push,
  output scl2x_job_t           q_job
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [CFG_W-1:0]     cfg_w_r, cfg_h_r;
  logic [WW-1:0]        w_eff;
  logic [ROW_LIM_W-1:0] h_eff;

  logic [CW-1:0]        col_r, col_nxt;
  logic [POS_W-1:0]     row_r, row_nxt;
  logic [WW-1:0]        col_inc;
  logic [ROW_LIM_W-1:0] row_inc;
  logic                 has_right, last_row;
  logic [CW-1:0]        rd_addr_n;

  logic                 accept, pix_acc, stage_go;

  logic [PIX_W-1:0]     ls0_mem [MAX_WIDTH];
  logic [PIX_W-1:0]     ls1_mem [MAX_WIDTH];
  logic [PIX_W-1:0]     rd_x0_r, rd_x1_r, rd_n0_r, rd_n1_r;

  logic                 sv_r;
  logic                 s_pixel_r;
  logic [PIX_W-1:0]     s_pix_r;
  logic [COLOR_W-1:0]   s_color_r;
  logic [CW-1:0]        s_col_r;
  logic [POS_W-1:0]     s_row_r;
  logic                 s_top_r, s_up2_r, s_left_r, s_left2_r, s_right_r;
  logic                 s_last_row_r, s_row_end_r;

  logic [PIX_W-1:0]     prv_m1_r, cur_m1_r, cur_m2_r;
  logic [PIX_W-1:0]     prv_x, prv_n, old_x;
  scl2x_blk_t           blk_a, blk_b, blk_c;
  logic [BLK_SLOTS-1:0] blk_vld;

  always_comb begin
    if (cfg_w_r == '0) begin
      w_eff = WW'(1);
    end else if (int'(cfg_w_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_w_r);
    end
    if (cfg_h_r == '0) begin
      h_eff = ROW_LIM_W'(1);
    end else if (cfg_h_r > MAX_ROWS) begin
      h_eff = MAX_ROWS;
    end else begin
      h_eff = cfg_h_r;
    end
  end

  assign col_inc   = WW'(col_r) + WW'(1);
  assign has_right = col_inc < w_eff;
  assign row_inc   = ROW_LIM_W'(row_r) + ROW_LIM_W'(1);
  assign last_row  = row_inc == h_eff;
  assign rd_addr_n = has_right ? CW'(col_inc) : col_r;

  always_comb begin
    col_nxt = has_right ? CW'(col_inc) : '0;
    row_nxt = row_r;
    if (!has_right) begin
      row_nxt = last_row ? '0 : POS_W'(row_inc);
    end
  end

  assign stage_go = sv_r && !q_stat.full;
  assign in_stall = sv_r && q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign pix_acc  = accept && (in_data.func == FUNC_PIXEL);

  // configuration and raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= FRAME_WIDTH_RST;
      cfg_h_r <= FRAME_HEIGHT_RST;
      col_r   <= '0;
      row_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH: begin
          cfg_w_r <= cfg_wdata;
          col_r   <= '0;
          row_r   <= '0;
        end
        CFG_FRAME_HEIGHT: begin
          cfg_h_r <= cfg_wdata;
          col_r   <= '0;
          row_r   <= '0;
        end
        default: ;
      endcase
    end else if (pix_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line stores: read old contents at x and x+1, write pixel into current row
  always_ff @(posedge clk) begin
    if (pix_acc) begin
      if (row_r[0]) begin
        ls1_mem[col_r] <= in_data.pixel_index;
      end else begin
        ls0_mem[col_r] <= in_data.pixel_index;
      end
      rd_x0_r <= ls0_mem[col_r];
      rd_x1_r <= ls1_mem[col_r];
      rd_n0_r <= ls0_mem[rd_addr_n];
      rd_n1_r <= ls1_mem[rd_addr_n];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
    end else if (accept) begin
      sv_r <= 1'b1;
    end else if (stage_go) begin
      sv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_pixel_r    <= in_data.func == FUNC_PIXEL;
      s_pix_r      <= in_data.pixel_index;
      s_color_r    <= in_data.palette_color;
      s_col_r      <= col_r;
      s_row_r      <= row_r;
      s_top_r      <= row_r != '0;
      s_up2_r      <= row_r > POS_W'(1);
      s_left_r     <= col_r != '0;
      s_left2_r    <= col_r > CW'(1);
      s_right_r    <= has_right;
      s_last_row_r <= last_row;
      s_row_end_r  <= !has_right;
    end
  end

  // hold the left neighbors of the next pixel
  always_ff @(posedge clk) begin
    if (stage_go && s_pixel_r) begin
      prv_m1_r <= prv_x;
      cur_m2_r <= cur_m1_r;
      cur_m1_r <= s_pix_r;
    end
  end

  assign prv_x = s_row_r[0] ? rd_x0_r : rd_x1_r;
  assign prv_n = s_row_r[0] ? rd_n0_r : rd_n1_r;
  assign old_x = s_row_r[0] ? rd_x1_r : rd_x0_r;

  always_comb begin
    blk_a.col = POS_W'(s_col_r);
    blk_a.row = s_row_r - POS_W'(1);
    blk_a.ctr = prv_x;
    blk_a.up  = s_up2_r   ? old_x    : prv_x;
    blk_a.dn  = s_left_r  ? prv_m1_r : prv_x;
    blk_a.rt  = s_right_r ? prv_n    : prv_x;
    blk_a.lo  = s_pix_r;

    blk_b.col = POS_W'(s_col_r - CW'(1));
    blk_b.row = s_row_r;
    blk_b.ctr = cur_m1_r;
    blk_b.up  = s_top_r   ? prv_m1_r : cur_m1_r;
    blk_b.dn  = s_left2_r ? cur_m2_r : cur_m1_r;
    blk_b.rt  = s_pix_r;
    blk_b.lo  = cur_m1_r;

    blk_c.col = POS_W'(s_col_r);
    blk_c.row = s_row_r;
    blk_c.ctr = s_pix_r;
    blk_c.up  = s_top_r  ? prv_x    : s_pix_r;
    blk_c.dn  = s_left_r ? cur_m1_r : s_pix_r;
    blk_c.rt  = s_pix_r;
    blk_c.lo  = s_pix_r;

    blk_vld[0] = s_top_r;
    blk_vld[1] = s_last_row_r && s_left_r;
    blk_vld[2] = s_last_row_r && s_row_end_r;
  end

  always_comb begin
    q_job.is_pixel  = s_pixel_r;
    q_job.blk_vld   = s_pixel_r ? blk_vld : '0;
    q_job.blk[0]    = blk_a;
    q_job.blk[1]    = blk_b;
    q_job.blk[2]    = blk_c;
    q_job.pal_addr  = s_pix_r;
    q_job.pal_color = s_color_r;
  end

  // drop pixels that produce no block
  assign q_push = stage_go && (!s_pixel_r || (blk_vld != '0));

endmodule

// ===== sv/scl2x_queue.sv =====
`timescale 1ns / 1ps

module scl2x_queue import scl2x_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  scl2x_job_t   push_job,
  input  logic         pop,
  output scl2x_qstat_t stat,
  output scl2x_job_t   head
);

  localparam int PW   = $clog2(QUEUE_DEPTH);
  localparam int CNTW = PW + 1;

  scl2x_job_t       slot_r [QUEUE_DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;

  assign stat.full  = cnt_r == CNTW'(QUEUE_DEPTH);
  assign stat.empty = cnt_r == '0;
  assign head       = slot_r[rp_r];

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNTW'(1);
      2'b01:   cnt_nxt = cnt_r - CNTW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_job;
    end
  end

endmodule

// ===== sv/scl2x_back.sv =====
`timescale 1ns / 1ps

module scl2x_back import scl2x_pkg::*; #(
  parameter int COLOR_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  scl2x_qstat_t q_stat,
  input  scl2x_job_t   q_head,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_stall,
  output scl2x_out_t   out_data
);

  // three copies of the palette give five reads per cycle
  logic [COLOR_BITS-1:0] pal0_mem [PAL_DEPTH];
  logic [COLOR_BITS-1:0] pal1_mem [PAL_DEPTH];
  logic [COLOR_BITS-1:0] pal2_mem [PAL_DEPTH];

  logic [BLK_SLOTS-1:0]  done_r, pend, sel_oh;
  logic                  is_last;
  scl2x_blk_t            blk_cur;
  logic                  take, pix_fire, wr_fire;

  logic                  ov_r;
  logic [POS_W-1:0]      col_r, row_r;
  logic                  last_r;
  logic [COLOR_BITS-1:0] up_r, dn_r, ctr_r, rt_r, lo_r;
  logic [COLOR_BITS-1:0] tl, tr, bl, br;
  logic                  rule_on;

  assign pend = q_head.blk_vld & ~done_r;

  always_comb begin
    if (pend[0]) begin
      sel_oh  = 3'b001;
      blk_cur = q_head.blk[0];
    end else if (pend[1]) begin
      sel_oh  = 3'b010;
      blk_cur = q_head.blk[1];
    end else begin
      sel_oh  = 3'b100;
      blk_cur = q_head.blk[2];
    end
  end

  assign is_last  = (pend & ~sel_oh) == '0;
  assign take     = !ov_r || !out_stall;
  assign pix_fire = !q_stat.empty && q_head.is_pixel && take;
  assign wr_fire  = !q_stat.empty && !q_head.is_pixel;
  assign q_pop    = wr_fire || (pix_fire && is_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (q_pop) begin
        done_r <= '0;
      end else if (pix_fire) begin
        done_r <= done_r | sel_oh;
      end
      if (take) begin
        ov_r <= pix_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      pal0_mem[q_head.pal_addr] <= q_head.pal_color[COLOR_BITS-1:0];
      pal1_mem[q_head.pal_addr] <= q_head.pal_color[COLOR_BITS-1:0];
      pal2_mem[q_head.pal_addr] <= q_head.pal_color[COLOR_BITS-1:0];
    end
    if (pix_fire) begin
      up_r   <= pal0_mem[blk_cur.up];
      dn_r   <= pal0_mem[blk_cur.dn];
      ctr_r  <= pal1_mem[blk_cur.ctr];
      rt_r   <= pal1_mem[blk_cur.rt];
      lo_r   <= pal2_mem[blk_cur.lo];
      col_r  <= blk_cur.col;
      row_r  <= blk_cur.row;
      last_r <= is_last;
    end
  end

  assign rule_on = (up_r != lo_r) && (dn_r != rt_r);
  assign tl = (rule_on && (dn_r == up_r)) ? dn_r : ctr_r;
  assign tr = (rule_on && (up_r == rt_r)) ? rt_r : ctr_r;
  assign bl = (rule_on && (dn_r == lo_r)) ? dn_r : ctr_r;
  assign br = (rule_on && (lo_r == rt_r)) ? rt_r : ctr_r;

  assign out_valid = ov_r;

  always_comb begin
    out_data.src_col      = col_r;
    out_data.src_row      = row_r;
    out_data.top_left     = COLOR_W'(tl);
    out_data.top_right    = COLOR_W'(tr);
    out_data.bottom_left  = COLOR_W'(bl);
    out_data.bottom_right = COLOR_W'(br);
    out_data.last_of_run  = last_r;
  end

endmodule
